@@ design/ptlc_pkg.sv @@
// Shared types, codes and constants of the pulse-triggered LED chaser.
`default_nettype none
package ptlc_pkg;

  localparam int PIXELS_DEF      = 32;
  localparam int FADE_STEPS_DEF  = 16;
  localparam int COLOR_COUNT_DEF = 4;

  localparam int IDX_W   = 6;
  localparam int CH_W    = 8;
  localparam int RGB_W   = 3 * CH_W;
  localparam int TIMER_W = 16;
  localparam int DIM_W   = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = RGB_W;

  localparam logic [CH_W-1:0]    CH_MAX      = 8'hFF;
  localparam logic [CH_W-1:0]    RED_FLOOR   = 8'd3;
  localparam logic [CH_W-1:0]    GREEN_FLOOR = 8'd1;
  localparam logic [TIMER_W-1:0] TIMER_MAX   = 16'hFFFF;

  localparam logic [TIMER_W-1:0] STEP_PERIOD_RST = 16'd30;
  localparam logic [DIM_W-1:0]   DIM_FACTOR_RST  = 9'd230;
  localparam logic [RGB_W-1:0]   COLOR_0_RST     = 24'hFF0000;
  localparam logic [RGB_W-1:0]   COLOR_1_RST     = 24'hFFFF00;
  localparam logic [RGB_W-1:0]   COLOR_2_RST     = 24'h00FFFF;
  localparam logic [RGB_W-1:0]   COLOR_3_RST     = 24'h800080;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_FACTOR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_0     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_1     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_2     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_3     = 3'd5;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_ACTIVE = 2'd1,
    MODE_PEAK   = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_MUL   = 3'd1,
    ST_DIV   = 3'd2,
    ST_READ  = 3'd3,
    ST_WRITE = 3'd4
  } state_t;

endpackage
`default_nettype wire

@@ design/ptlc_tick_if.sv @@
// Channel carrying one detector status item per tick.
`default_nettype none
interface ptlc_tick_if;
  logic valid;
  logic ready;
  logic sensor_available;
  logic detection_active;
  logic peak_detected;

  modport source (output valid, sensor_available, detection_active, peak_detected,
                  input ready);
  modport sink   (input valid, sensor_available, detection_active, peak_detected,
                  output ready);
endinterface
`default_nettype wire

@@ design/ptlc_pixel_if.sv @@
// Channel carrying one pixel colour item of an emitted frame.
`default_nettype none
interface ptlc_pixel_if
  import ptlc_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] pixel_index;
  logic [CH_W-1:0]  red;
  logic [CH_W-1:0]  green;
  logic [CH_W-1:0]  blue;
  logic             frame_last;

  modport source (output valid, pixel_index, red, green, blue, frame_last,
                  input ready);
  modport sink   (input valid, pixel_index, red, green, blue, frame_last,
                  output ready);
endinterface
`default_nettype wire

@@ design/pulse_triggered_led_chaser.sv @@
// Pulse-triggered LED chaser: status update, frame store sweep and colour fade.
//
// Usage: every tick item on the tick channel carries the detector status.
// The block updates its mode and head and counts ticks; once the count
// exceeds step_period an animation step runs and the whole frame, PIXELS
// pixel items in index order with frame_last on the final one, leaves on
// the pixel channel. Ticks without a step yield no item.
// Sweep: a tick without a step is taken in the idle state, which it does not
// leave. A step sweeps the single-port frame store, one read and one
// write-back per pixel; on a blend step (peak mode, head not past the far
// end) a weighted-sum state and a reciprocal-multiply state come first.
// No tick is taken while a step is in progress.
// Reset: control state and configuration return to their reset values,
// data registers are not reset; the frame store reads as all pixels off
// through per-entry valid bits, so no clearing pass is needed.
// Stall: the pixel output is registered; while the receiver holds ready
// low the sweep waits on the pending pixel and nothing is lost.
// Configuration is to be written through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
`default_nettype none
module pulse_triggered_led_chaser
  import ptlc_pkg::*;
#(
  parameter int PIXELS      = PIXELS_DEF,
  parameter int FADE_STEPS  = FADE_STEPS_DEF,
  parameter int COLOR_COUNT = COLOR_COUNT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  ptlc_tick_if.sink                  tick,
  ptlc_pixel_if.source               pixel
);

  localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int HW = $clog2(PIXELS + 2);
  localparam int FW = $clog2(FADE_STEPS + 1);
  localparam int NW = 17;
  localparam int RW = 16;
  localparam int RS = RW + $clog2(FADE_STEPS);
  localparam int MW = RW + 1;
  localparam int PW = RW + MW;

  localparam logic [AW-1:0] PIX_LAST   = AW'(PIXELS - 1);
  localparam logic [HW-1:0] HEAD_END   = HW'(PIXELS);
  localparam logic [FW-1:0] FADE_END   = FW'(FADE_STEPS);
  localparam logic [1:0]    SLOT_LAST  = 2'(COLOR_COUNT - 1);
  localparam logic [DIM_W-1:0] FADE_W9 = DIM_W'(FADE_STEPS);
  // ceil(2^RS / FADE_STEPS): exact floor quotient for any 16-bit weighted sum
  localparam logic [MW-1:0] FADE_RECIP =
    MW'(((longint'(1) << RS) + longint'(FADE_STEPS) - 1) / longint'(FADE_STEPS));

  // configuration registers
  logic [TIMER_W-1:0] step_period;
  logic [DIM_W-1:0]   dim_factor;
  logic [RGB_W-1:0]   color_0, color_1, color_2, color_3;

  // animation state
  state_t             state, state_next;
  mode_t              mode;
  logic [HW-1:0]      head;
  logic [TIMER_W-1:0] tick_elapsed;
  logic [1:0]         color_slot;
  logic [FW-1:0]      fade_progress;

  // step context
  logic               floor_en;
  logic               paint_en;
  logic [HW-1:0]      paint_idx;
  logic [RGB_W-1:0]   from_c, to_c;
  logic [FW-1:0]      blend_p;
  logic [RW-1:0]      wsum [3];
  logic [CH_W-1:0]    quo [3];
  logic [AW-1:0]      pix;

  // frame store
  logic [RGB_W-1:0]   fs_mem [PIXELS];
  logic [PIXELS-1:0]  fs_valid;
  logic [RGB_W-1:0]   rd_data;
  logic               rd_valid;

  // output register
  logic               out_valid;
  logic [IDX_W-1:0]   out_index;
  logic [RGB_W-1:0]   out_rgb;
  logic               out_last;

  // control decode
  logic in_ready, mem_rd, wr_go, out_free;

  function automatic logic [RGB_W-1:0] pick_color(input logic [1:0] s,
                                                  input logic [RGB_W-1:0] c0,
                                                  input logic [RGB_W-1:0] c1,
                                                  input logic [RGB_W-1:0] c2,
                                                  input logic [RGB_W-1:0] c3);
    logic [RGB_W-1:0] c;
    case (s)
      2'd0:    c = c0;
      2'd1:    c = c1;
      2'd2:    c = c2;
      default: c = c3;
    endcase
    return c;
  endfunction

  function automatic logic [CH_W-1:0] dim_ch(input logic [CH_W-1:0] c,
                                             input logic [DIM_W-1:0] f);
    logic [NW-1:0] p;
    p = NW'(c) * NW'(f);
    return (p[NW-1:8] > NW'(CH_MAX)) ? CH_MAX : p[15:8];
  endfunction

  // ---------------------------------------------------------------------------
  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_period <= STEP_PERIOD_RST;
      dim_factor  <= DIM_FACTOR_RST;
      color_0     <= COLOR_0_RST;
      color_1     <= COLOR_1_RST;
      color_2     <= COLOR_2_RST;
      color_3     <= COLOR_3_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_PERIOD: step_period <= cfg_data[TIMER_W-1:0];
        CFG_DIM_FACTOR:  dim_factor  <= cfg_data[DIM_W-1:0];
        CFG_COLOR_0:     color_0     <= cfg_data;
        CFG_COLOR_1:     color_1     <= cfg_data;
        CFG_COLOR_2:     color_2     <= cfg_data;
        CFG_COLOR_3:     color_3     <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // status update, timer and sequencer for the item on the tick channel
  mode_t              mode_u, mode_s;
  logic [HW-1:0]      head_u, head_s;
  logic [TIMER_W-1:0] te_inc;
  logic               step_u, blend_u;
  logic [1:0]         slot_inc, slot_e, slot_to;
  logic [FW-1:0]      fade_e;

  always_comb begin
    mode_u = mode;
    head_u = head;
    if (tick.sensor_available) begin
      if (tick.detection_active) begin
        if (tick.peak_detected) begin
          mode_u = MODE_PEAK;
          head_u = '0;
        end else if (mode != MODE_PEAK) begin
          mode_u = MODE_ACTIVE;
        end
      end else begin
        mode_u = MODE_IDLE;
        head_u = '0;
      end
    end

    te_inc = (tick_elapsed == TIMER_MAX) ? tick_elapsed : tick_elapsed + 1'b1;
    step_u = te_inc > step_period;

    // head paints while it has not passed the far end, else fall back
    blend_u = step_u && (mode_u == MODE_PEAK) && (head_u <= HEAD_END);
    mode_s  = mode_u;
    head_s  = head_u;
    if (step_u && (mode_u == MODE_PEAK)) begin
      if (head_u <= HEAD_END) head_s = head_u + 1'b1;
      else                    mode_s = MODE_ACTIVE;
    end

    slot_inc = (color_slot == SLOT_LAST) ? 2'd0 : color_slot + 1'b1;
    if (fade_progress >= FADE_END) begin
      fade_e = '0;
      slot_e = slot_inc;
    end else begin
      fade_e = fade_progress;
      slot_e = color_slot;
    end
    slot_to = (slot_e == SLOT_LAST) ? 2'd0 : slot_e + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      head          <= '0;
      tick_elapsed  <= '0;
      color_slot    <= '0;
      fade_progress <= '0;
      paint_en      <= 1'b0;
      floor_en      <= 1'b0;
    end else if (tick.valid && in_ready) begin
      mode         <= mode_s;
      head         <= head_s;
      tick_elapsed <= step_u ? '0 : te_inc;
      floor_en     <= mode_u != MODE_IDLE;
      // index PIXELS lies off the strip: advance the sequencer, drop the colour
      paint_en     <= blend_u && (head_u != '0);
      if (blend_u) begin
        color_slot    <= slot_e;
        fade_progress <= fade_e + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && in_ready) begin
      paint_idx <= HEAD_END - head_u;
      blend_p   <= fade_e;
      from_c    <= pick_color(slot_e, color_0, color_1, color_2, color_3);
      to_c      <= pick_color(slot_to, color_0, color_1, color_2, color_3);
    end
  end

  // ---------------------------------------------------------------------------
  // colour blend: weighted sum, then divide by FADE_STEPS through a reciprocal
  logic [DIM_W-1:0] w_from;
  logic [NW-1:0]    num [3];
  logic [PW-1:0]    scaled [3];

  always_comb begin
    w_from = FADE_W9 - DIM_W'(blend_p);
    for (int c = 0; c < 3; c++) begin
      num[c]    = NW'(to_c[CH_W*c +: CH_W]) * NW'(blend_p)
                + NW'(from_c[CH_W*c +: CH_W]) * NW'(w_from);
      scaled[c] = PW'(wsum[c]) * PW'(FADE_RECIP);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (state == ST_MUL) wsum[c] <= num[c][RW-1:0];
      if (state == ST_DIV) quo[c]  <= scaled[c][RS +: CH_W];
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (tick.valid && step_u) state_next = blend_u ? ST_MUL : ST_READ;
      ST_MUL:   state_next = ST_DIV;
      ST_DIV:   state_next = ST_READ;
      ST_READ:  state_next = ST_WRITE;
      ST_WRITE: if (out_free) state_next = (pix == PIX_LAST) ? ST_IDLE : ST_READ;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_free = !out_valid || pixel.ready;
    in_ready = 1'b0;
    mem_rd   = 1'b0;
    wr_go    = 1'b0;
    unique case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_READ:  mem_rd   = 1'b1;
      ST_WRITE: wr_go    = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pix   <= '0;
    end else begin
      state <= state_next;
      if (wr_go) pix <= (pix == PIX_LAST) ? '0 : pix + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // frame store: read, dim and floor, paint, write back
  logic [CH_W-1:0]  r_old, g_old, b_old, r_dim, g_dim, b_dim;
  logic [RGB_W-1:0] px_new;

  always_comb begin
    r_old = rd_valid ? rd_data[23:16] : '0;
    g_old = rd_valid ? rd_data[15:8]  : '0;
    b_old = rd_valid ? rd_data[7:0]   : '0;
    r_dim = dim_ch(r_old, dim_factor);
    g_dim = dim_ch(g_old, dim_factor);
    b_dim = dim_ch(b_old, dim_factor);
    if (floor_en) begin
      if (r_dim < RED_FLOOR)   r_dim = RED_FLOOR;
      if (g_dim < GREEN_FLOOR) g_dim = GREEN_FLOOR;
    end
    if (paint_en && (HW'(pix) == paint_idx)) px_new = {quo[2], quo[1], quo[0]};
    else                                     px_new = {r_dim, g_dim, b_dim};
  end

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      rd_data  <= fs_mem[pix];
      rd_valid <= fs_valid[pix];
    end
    if (wr_go) fs_mem[pix] <= px_new;
  end

  always_ff @(posedge clk) begin
    if (rst)        fs_valid      <= '0;
    else if (wr_go) fs_valid[pix] <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // output register
  always_ff @(posedge clk) begin
    if (rst)               out_valid <= 1'b0;
    else if (wr_go)        out_valid <= 1'b1;
    else if (pixel.ready)  out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (wr_go) begin
      out_index <= IDX_W'(pix);
      out_rgb   <= px_new;
      out_last  <= pix == PIX_LAST;
    end
  end

  assign tick.ready        = in_ready;
  assign pixel.valid       = out_valid;
  assign pixel.pixel_index = out_index;
  assign pixel.red         = out_rgb[23:16];
  assign pixel.green       = out_rgb[15:8];
  assign pixel.blue        = out_rgb[7:0];
  assign pixel.frame_last  = out_last;

  // ---------------------------------------------------------------------------
  // checks
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    pixel.valid && pixel.frame_last |-> pixel.pixel_index == IDX_W'(PIXELS - 1))
    else $error("frame_last on a pixel other than the final one");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    head <= HW'(PIXELS + 1))
    else $error("head beyond the end of its range");

  a_fade_range: assert property (@(posedge clk) disable iff (rst)
    fade_progress <= FADE_END)
    else $error("fade progress beyond FADE_STEPS");

  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    tick.valid && tick.ready && step_u |=> !tick.ready)
    else $error("tick taken while a step sweep starts");

endmodule
`default_nettype wire
